/* hw/rtl/midi_running_status_parser_unit_assert.svh */
// Assertion macros for the MIDI parser checker.
`ifndef MIDI_RUNNING_STATUS_PARSER_UNIT_ASSERT_SVH
`define MIDI_RUNNING_STATUS_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define MRSP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define MRSP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mrsp_pkg.sv */
// Package: codes, state and result types of the MIDI running status parser.
package mrsp_pkg;

    // Event / running status kinds
    localparam logic [2:0] KIND_NONE        = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON     = 3'd1;
    localparam logic [2:0] KIND_NOTE_OFF    = 3'd2;
    localparam logic [2:0] KIND_CONTROL     = 3'd3;
    localparam logic [2:0] KIND_PITCH       = 3'd4;
    localparam logic [2:0] KIND_UNSUPPORTED = 3'd5;

    // Data byte phases
    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_FIRST  = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;

    // Status groups, bits [6:4] of a status byte
    localparam logic [2:0] GRP_NOTE_OFF   = 3'h0;
    localparam logic [2:0] GRP_NOTE_ON    = 3'h1;
    localparam logic [2:0] GRP_AFTERTOUCH = 3'h2;
    localparam logic [2:0] GRP_CONTROLLER = 3'h3;
    localparam logic [2:0] GRP_PROGRAM    = 3'h4;
    localparam logic [2:0] GRP_PRESSURE   = 3'h5;
    localparam logic [2:0] GRP_PITCH      = 3'h6;
    localparam logic [2:0] GRP_SYSTEM     = 3'h7;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] phase;
        logic [6:0] held_first;
        logic [7:0] duty_a;
        logic [7:0] duty_b;
    } parser_state_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [6:0] first_value;
        logic [6:0] second_value;
    } parser_event_t;

endpackage

/* hw/rtl/mrsp_step.sv */
// Combinational step: one MIDI byte against the current parser state.
module mrsp_step
(
    input  logic [7:0]             byte_in,
    input  mrsp_pkg::parser_state_t state_cur,
    output mrsp_pkg::parser_state_t state_next,
    output mrsp_pkg::parser_event_t event_out
);
    import mrsp_pkg::*;

    logic [2:0] ev_kind;
    logic [7:0] duty_new;

    assign duty_new = {byte_in[6:0], 1'b0};

    always_comb
    begin
        state_next = state_cur;
        ev_kind    = KIND_NONE;

        if (byte_in[7])
        begin
            unique case (byte_in[6:4])
                GRP_NOTE_OFF:
                begin
                    state_next.kind  = KIND_NOTE_OFF;
                    state_next.phase = PHASE_FIRST;
                end
                GRP_NOTE_ON:
                begin
                    state_next.kind  = KIND_NOTE_ON;
                    state_next.phase = PHASE_FIRST;
                end
                GRP_AFTERTOUCH, GRP_CONTROLLER:
                begin
                    state_next.kind  = KIND_CONTROL;
                    state_next.phase = PHASE_FIRST;
                end
                GRP_PITCH:
                begin
                    state_next.kind  = KIND_PITCH;
                    state_next.phase = PHASE_FIRST;
                end
                GRP_PROGRAM, GRP_PRESSURE:
                begin
                    state_next.kind = KIND_UNSUPPORTED;
                end
                GRP_SYSTEM:
                begin
                    // system common only; realtime leaves everything alone
                    if (!byte_in[3])
                    begin
                        state_next.kind = KIND_UNSUPPORTED;
                    end
                end
            endcase
        end
        else if (state_cur.phase == PHASE_FIRST)
        begin
            state_next.held_first = byte_in[6:0];
            state_next.phase      = PHASE_SECOND;
        end
        else if (state_cur.phase == PHASE_SECOND)
        begin
            state_next.phase = PHASE_FIRST;
            unique case (state_cur.kind)
                KIND_NOTE_ON:
                begin
                    ev_kind = (byte_in[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                    state_next.held_first = 7'd0;
                end
                KIND_NOTE_OFF:
                begin
                    ev_kind = KIND_NOTE_OFF;
                    state_next.held_first = 7'd0;
                end
                KIND_CONTROL:
                begin
                    ev_kind = KIND_CONTROL;
                    state_next.duty_a = duty_new;
                    state_next.duty_b = ~duty_new;   // 255 - 2v
                end
                KIND_PITCH:
                begin
                    ev_kind = KIND_PITCH;
                    state_next.held_first = 7'd0;
                end
                default:
                begin
                    ev_kind = KIND_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        event_out.event_kind   = ev_kind;
        event_out.first_value  = (ev_kind == KIND_NONE) ? 7'd0 : state_cur.held_first;
        event_out.second_value = (ev_kind == KIND_NONE) ? 7'd0 : byte_in[6:0];
    end

endmodule

/* hw/rtl/midi_running_status_parser_unit.sv */
// Top level: MIDI running status parser with registered input and result stages.
//
// Input channel: one received MIDI byte per transfer on incoming_byte
// (in_valid / in_ready). Every byte, status, data or realtime, gives exactly
// one result transfer on the output channel (out_valid / out_ready).
// A result carries event_kind (0 none, 1 note on, 2 note off, 3 control,
// 4 pitch wheel), the two data bytes when an event completes, and the two
// PWM duties as they stand after the byte.
// A byte taken into the input stage is decoded against the parser state as
// it moves to the result stage, and is shown on the output from then on.
// Throughput: one byte per cycle while the output is free or being taken;
// both stages then advance together.
// Stall: while out_ready is low the result is held; one more byte can wait
// in the input stage, after which in_ready drops until the result goes.
// Reset (rst_n low, asynchronous): no status seen, not collecting, held
// data byte and both duties cleared, both stages emptied.
module midi_running_status_parser_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] incoming_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_kind,
    output logic [6:0] first_value,
    output logic [6:0] second_value,
    output logic [7:0] duty_up,
    output logic [7:0] duty_down
);
    import mrsp_pkg::*;

    // input stage
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    // parser state, updated as a byte moves to the result stage
    parser_state_t state_reg;
    parser_state_t state_next;
    parser_event_t event_next;
    // result stage
    logic          out_valid_reg;
    parser_event_t event_reg;
    logic [7:0]    duty_up_reg;
    logic [7:0]    duty_down_reg;

    logic advance;

    // byte moves from input stage to result stage when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    mrsp_step u_step
    (
        .byte_in    (in_byte_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .event_out  (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= incoming_byte;
        end
        if (advance)
        begin
            event_reg     <= event_next;
            duty_up_reg   <= state_next.duty_a;
            duty_down_reg <= state_next.duty_b;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = event_reg.event_kind;
    assign first_value  = event_reg.first_value;
    assign second_value = event_reg.second_value;
    assign duty_up      = duty_up_reg;
    assign duty_down    = duty_down_reg;

endmodule

/* hw/rtl/mrsp_checker.sv */
// Port-level checker for the MIDI parser, bound to the top level.
`include "midi_running_status_parser_unit_assert.svh"

module mrsp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] incoming_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_kind,
    input logic [6:0] first_value,
    input logic [6:0] second_value,
    input logic [7:0] duty_up,
    input logic [7:0] duty_down
);
    import mrsp_pkg::*;

    logic in_stall;
    logic out_stall;
    logic none_shown;
    logic note_on_shown;
    logic ctrl_shown;
    logic data_zero;
    logic ctrl_duty_ok;

    assign in_stall      = in_valid && !in_ready;
    assign out_stall     = out_valid && !out_ready;
    assign none_shown    = out_valid && (event_kind == KIND_NONE);
    assign note_on_shown = out_valid && (event_kind == KIND_NOTE_ON);
    assign ctrl_shown    = out_valid && (event_kind == KIND_CONTROL);
    assign data_zero     = (first_value == 7'd0) && (second_value == 7'd0);
    // duty_up is twice the value, duty_down its complement (255 - 2v)
    assign ctrl_duty_ok  = (duty_up == {second_value, 1'b0}) && (duty_down == ~duty_up);

    `MRSP_ASSERT_NXT(a_in_hold, in_stall, in_valid && $stable(incoming_byte), "input not held")

    `MRSP_ASSERT_NXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")

    `MRSP_ASSERT_IMP(a_none_zero, none_shown, data_zero, "empty result carries data")

    `MRSP_ASSERT_IMP(a_ctrl_duty, ctrl_shown, ctrl_duty_ok, "duties off control value")

    `MRSP_ASSERT_IMP(a_note_vel, note_on_shown, |second_value, "note on with zero velocity")

endmodule

bind midi_running_status_parser_unit mrsp_checker u_mrsp_checker (.*);
